### design/array_stack_with_search_assert.svh
// assertion macros for the array stack with search
// no dependencies; included by the top level
`ifndef ARRAY_STACK_WITH_SEARCH_ASSERT_SVH
`define ARRAY_STACK_WITH_SEARCH_ASSERT_SVH
`ifndef SYNTHESIS
`define STK_ASSERT_SAME(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);
`define STK_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);
`else
`define STK_ASSERT_SAME(lbl, clk, rst_n, pre, post, msg)
`define STK_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

### design/stksrch_pkg.sv
// shared types and constants for the array stack with search
// no dependencies
package stksrch_pkg;

  localparam int DEPTH  = 128;
  localparam int WORD_W = 32;
  localparam int POS_W  = 7;
  localparam int CAP_W  = 8;
  localparam int FILL_W = $clog2(DEPTH + 1);
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CMP_W  = (FILL_W > POS_W) ? FILL_W : POS_W;
  localparam int LIM_W  = (FILL_W > CAP_W) ? FILL_W : CAP_W;

  localparam logic [2:0] CMD_PUSH   = 3'd0;
  localparam logic [2:0] CMD_POP    = 3'd1;
  localparam logic [2:0] CMD_PEEK   = 3'd2;
  localparam logic [2:0] CMD_READ   = 3'd3;
  localparam logic [2:0] CMD_WRITE  = 3'd4;
  localparam logic [2:0] CMD_SEARCH = 3'd5;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [1:0] ST_BADPOS    = 2'd3;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_PUSH,
    CELL_SHIFT
  } cell_op_t;

  typedef struct packed {
    logic [2:0]               cmd;
    logic signed [WORD_W-1:0] value;
    logic [POS_W-1:0]         position;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] data;
    logic [1:0]               status;
    logic [7:0]               match_count;
    logic [7:0]               occupancy;
  } out_item_t;

endpackage

### design/array_stack_with_search.sv
// top level of the array stack with search: capacity register, cell row, sequencer
// depends on stksrch_pkg, stksrch_cell, stksrch_ctl, array_stack_with_search_assert.svh
//
//  channel | direction | ports                         | item
//  --------+-----------+-------------------------------+------------------------------
//  in      | input     | in_valid, in_ready, in_item   | cmd, value, position
//  out     | output    | out_valid, out_ready, out_item| data, status, match_count, occ.
//  cfg     | input     | cfg_valid, cfg_ready, cfg_data| capacity
//
// push, pop, peek and every error result go straight into the result queue
// read, write and search rotate the cell row once
//   through cell 0, where the sequencer compares, captures or replaces a word
// reset empties the stack and sets capacity to 128; entries are not cleared
// a two-slot result queue lets the next item in while a result waits; the
//   input stalls only during a rotation or with both slots full
`include "array_stack_with_search_assert.svh"
module array_stack_with_search
  import stksrch_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_item,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_item,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CAP_W-1:0] cfg_data
);

  logic [CAP_W-1:0]  capacity_r;
  cell_op_t          cell_op;
  logic [WORD_W-1:0] push_word;
  logic [WORD_W-1:0] fb_word;
  logic [WORD_W-1:0] cell_q [DEPTH];

  // capacity register, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_W'(128);
    end else if (cfg_valid && cfg_ready) begin
      capacity_r <= cfg_data;
    end
  end

  stksrch_ctl u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .capacity  (capacity_r),
    .top_word  (cell_q[0]),
    .cell_op   (cell_op),
    .push_word (push_word),
    .fb_word   (fb_word)
  );

  // cell 0 is the top of the stack; push shifts toward the far end,
  // pop and rotate shift toward cell 0, with the last cell fed back from the sequencer
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_W-1:0] lo_word;
    logic [WORD_W-1:0] hi_word;
    if (i == 0) begin : g_first
      assign lo_word = push_word;
    end else begin : g_mid_lo
      assign lo_word = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign hi_word = fb_word;
    end else begin : g_mid_hi
      assign hi_word = cell_q[i+1];
    end
    stksrch_cell u_cell (
      .clk     (clk),
      .op      (cell_op),
      .from_lo (lo_word),
      .from_hi (hi_word),
      .q       (cell_q[i])
    );
  end

  // the row only takes a new top word on an accepted item
  `STK_ASSERT_SAME(a_push_on_accept, clk, rst_n, cell_op == CELL_PUSH, in_valid && in_ready, "push without accepted item")
  // an accepted push always leaves a result waiting in the next cycle
  `STK_ASSERT_NEXT(a_push_answers, clk, rst_n, in_valid && in_ready && in_item.cmd == CMD_PUSH, out_valid, "push result missing")
  // a capacity write lands in the register
  `STK_ASSERT_NEXT(a_cfg_lands, clk, rst_n, cfg_valid, capacity_r == $past(cfg_data), "capacity write lost")

endmodule

### design/stksrch_cell.sv
// one stack cell: holds one word, loads from the lower or upper neighbor
// depends on stksrch_pkg
module stksrch_cell
  import stksrch_pkg::*;
(
  input  logic              clk,
  input  cell_op_t          op,
  input  logic [WORD_W-1:0] from_lo,
  input  logic [WORD_W-1:0] from_hi,
  output logic [WORD_W-1:0] q
);

  logic [WORD_W-1:0] q_r;

  always_ff @(posedge clk) begin
    case (op)
      CELL_PUSH:  q_r <= from_lo;
      CELL_SHIFT: q_r <= from_hi;
      default:    q_r <= q_r;
    endcase
  end

  assign q = q_r;

endmodule

### design/stksrch_ctl.sv
// command sequencer: fill level, ring scan, two-slot result queue
// depends on stksrch_pkg
module stksrch_ctl
  import stksrch_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_item,
  input  logic [CAP_W-1:0]  capacity,
  input  logic [WORD_W-1:0] top_word,
  output cell_op_t          cell_op,
  output logic [WORD_W-1:0] push_word,
  output logic [WORD_W-1:0] fb_word
);

  typedef enum logic {S_IDLE, S_SCAN} state_t;

  state_t            state_r, state_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [IDX_W-1:0]  t_r, t_nxt;
  logic [IDX_W-1:0]  tgt_r, tgt_nxt;
  logic [WORD_W-1:0] key_r, key_nxt;
  logic [2:0]        cmd_r, cmd_nxt;
  logic [7:0]        cnt_r, cnt_nxt;
  out_item_t         slot0_r, slot0_nxt, slot1_r, slot1_nxt;
  logic [1:0]        ocnt_r, ocnt_nxt;

  logic              acc, deq, enq, start_scan, empty, pos_bad, full;
  logic              live, hit, last;
  logic [LIM_W-1:0]  lim;
  out_item_t         enq_item;

  assign in_ready  = (state_r == S_IDLE) && (ocnt_r != 2'd2);
  assign acc       = in_valid && in_ready;
  assign out_valid = (ocnt_r != 2'd0);
  assign out_item  = slot0_r;
  assign deq       = out_valid && out_ready;
  assign push_word = in_item.value;

  assign empty   = (fill_r == '0);
  assign pos_bad = CMP_W'(in_item.position) >= CMP_W'(fill_r);
  assign lim     = (LIM_W'(capacity) < LIM_W'(DEPTH)) ? LIM_W'(capacity) : LIM_W'(DEPTH);
  assign full    = LIM_W'(fill_r) >= lim;

  // ring scan bookkeeping
  assign live = CMP_W'(t_r) < CMP_W'(fill_r);
  assign hit  = (t_r == tgt_r);
  assign last = (t_r == IDX_W'(DEPTH - 1));

  always_comb begin
    state_nxt  = state_r;
    fill_nxt   = fill_r;
    t_nxt      = t_r;
    tgt_nxt    = tgt_r;
    key_nxt    = key_r;
    cmd_nxt    = cmd_r;
    cnt_nxt    = cnt_r;
    cell_op    = CELL_HOLD;
    fb_word    = top_word;
    start_scan = 1'b0;
    enq        = 1'b0;
    enq_item   = '0;

    if (state_r == S_IDLE) begin
      if (acc) begin
        enq = 1'b1;
        case (in_item.cmd)
          CMD_PUSH: begin
            if (full) begin
              enq_item.status = ST_OVERFLOW;
            end else begin
              cell_op  = CELL_PUSH;
              fill_nxt = fill_r + FILL_W'(1);
            end
          end
          CMD_POP: begin
            if (empty) begin
              enq_item.status = ST_UNDERFLOW;
            end else begin
              cell_op       = CELL_SHIFT;
              fill_nxt      = fill_r - FILL_W'(1);
              enq_item.data = top_word;
            end
          end
          CMD_PEEK: begin
            if (empty) enq_item.status = ST_UNDERFLOW;
            else       enq_item.data   = top_word;
          end
          CMD_READ, CMD_WRITE: begin
            if (empty)        enq_item.status = ST_UNDERFLOW;
            else if (pos_bad) enq_item.status = ST_BADPOS;
            else              start_scan      = 1'b1;
          end
          CMD_SEARCH: begin
            if (empty) enq_item.status = ST_UNDERFLOW;
            else       start_scan      = 1'b1;
          end
          default: ;
        endcase
        enq_item.occupancy = 8'(fill_nxt);
        if (start_scan) begin
          enq       = 1'b0;
          state_nxt = S_SCAN;
          t_nxt     = '0;
          cnt_nxt   = '0;
          key_nxt   = in_item.value;
          cmd_nxt   = in_item.cmd;
          tgt_nxt   = IDX_W'(CMP_W'(fill_r) - CMP_W'(1) - CMP_W'(in_item.position));
        end
      end
    end else begin
      // rotate the whole row once; cell 0 shows entry fill-1-t at step t
      cell_op = CELL_SHIFT;
      if (cmd_r == CMD_WRITE && hit) fb_word = key_r;
      if (cmd_r == CMD_SEARCH && live && top_word == key_r) cnt_nxt = cnt_r + 8'd1;
      // a read keeps the captured word in the key register until the end
      if (cmd_r == CMD_READ && hit) key_nxt = top_word;
      t_nxt = t_r + IDX_W'(1);
      if (last) begin
        enq = 1'b1;
        if (cmd_r == CMD_READ) enq_item.data = key_nxt;
        enq_item.match_count = cnt_nxt;
        enq_item.occupancy   = 8'(fill_r);
        state_nxt            = S_IDLE;
      end
    end
  end

  // two-slot result queue, slot 0 faces the port
  always_comb begin
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    ocnt_nxt  = ocnt_r;
    if (enq && deq) begin
      if (ocnt_r == 2'd1) begin
        slot0_nxt = enq_item;
      end else begin
        slot0_nxt = slot1_r;
        slot1_nxt = enq_item;
      end
    end else if (enq) begin
      if (ocnt_r == 2'd0) slot0_nxt = enq_item;
      else                slot1_nxt = enq_item;
      ocnt_nxt = ocnt_r + 2'd1;
    end else if (deq) begin
      slot0_nxt = slot1_r;
      ocnt_nxt  = ocnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= '0;
      ocnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      ocnt_r  <= ocnt_nxt;
    end
    t_r     <= t_nxt;
    tgt_r   <= tgt_nxt;
    key_r   <= key_nxt;
    cmd_r   <= cmd_nxt;
    cnt_r   <= cnt_nxt;
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

endmodule

### dv/array_stack_with_search_test.sv
// self-checking testbench for array_stack_with_search: directed and random commands
// depends on stksrch_pkg and the array_stack_with_search rtl; stack scoreboard class inside
`timescale 1ns / 100ps
module array_stack_with_search_test;
  import stksrch_pkg::*;

  // command codes the block treats as no-ops
  localparam logic [2:0] CMD_SPARE_A = 3'd6;
  localparam logic [2:0] CMD_SPARE_B = 3'd7;

  localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;

  // long receiver hold-off, long enough to fill the result slots and stall the input
  localparam int HOLD_CYCLES = 300;
  // run limit in nanoseconds; the run fails if it is reached
  localparam int RUN_LIMIT_NS = 8 * 600_000;

  // shadow stack: works out the result of every accepted command and checks
  // each delivered result against the oldest one still pending
  class stack_scoreboard;
    logic signed [WORD_W-1:0] words [DEPTH];
    int unsigned              level;
    logic [CAP_W-1:0]         cap;
    out_item_t                pending_q[$];
    int                       errors;

    function new();
      level  = 0;
      cap    = 8'd128;
      errors = 0;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] c);
      cap = c;
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("mismatch %0d: %s", errors, msg);
    endfunction

    function void note_command(in_item_t it);
      out_item_t   r;
      int unsigned lim;
      int unsigned hits;
      r    = '0;
      hits = 0;
      lim  = (cap < DEPTH) ? cap : DEPTH;
      r.status = ST_OK;
      case (it.cmd)
        CMD_PUSH: begin
          if (level >= lim) r.status = ST_OVERFLOW;
          else begin
            words[level] = it.value;
            level++;
          end
        end
        CMD_POP: begin
          if (level == 0) r.status = ST_UNDERFLOW;
          else begin
            level--;
            r.data = words[level];
          end
        end
        CMD_PEEK: begin
          if (level == 0) r.status = ST_UNDERFLOW;
          else r.data = words[level - 1];
        end
        CMD_READ: begin
          if (level == 0) r.status = ST_UNDERFLOW;
          else if (it.position >= level) r.status = ST_BADPOS;
          else r.data = words[it.position];
        end
        CMD_WRITE: begin
          if (level == 0) r.status = ST_UNDERFLOW;
          else if (it.position >= level) r.status = ST_BADPOS;
          else words[it.position] = it.value;
        end
        CMD_SEARCH: begin
          if (level == 0) r.status = ST_UNDERFLOW;
          else begin
            for (int k = 0; k < level; k++)
              if (words[k] == it.value) hits++;
            r.match_count = hits[7:0];
          end
        end
        default: ;
      endcase
      r.occupancy = level[7:0];
      pending_q.push_back(r);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_q.size() == 0) begin
        flag($sformatf("unexpected result: data %0d status %0d count %0d occ %0d",
                       got.data, got.status, got.match_count, got.occupancy));
        return;
      end
      want = pending_q.pop_front();
      if (got.data !== want.data)
        flag($sformatf("data expected %0d got %0d", want.data, got.data));
      if (got.status !== want.status)
        flag($sformatf("status expected %0d got %0d", want.status, got.status));
      if (got.match_count !== want.match_count)
        flag($sformatf("match_count expected %0d got %0d", want.match_count,
                       got.match_count));
      if (got.occupancy !== want.occupancy)
        flag($sformatf("occupancy expected %0d got %0d", want.occupancy, got.occupancy));
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  in_item_t         in_item = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_item_t        out_item;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CAP_W-1:0] cfg_data = '0;

  stack_scoreboard sb = new();

  // idling knobs, percent of cycles
  int send_idle  = 0;
  int recv_stall = 0;

  // hold-off request from the stimulus, counted down by the receiver
  bit hold_req  = 1'b0;
  int hold_left = 0;

  // small pool of keys so searches find repeated words
  logic signed [WORD_W-1:0] key_pool [6];

  array_stack_with_search dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver: random stalls, or a long hold-off when asked for one
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  // monitor: every handshake seen at the edge goes to the scoreboard,
  // inputs before results so a same-edge pair is still in order
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.set_capacity(cfg_data);
      if (in_valid && in_ready) sb.note_command(in_item);
      if (out_valid && out_ready) sb.check_result(out_item);
    end
  end

  // offer one item; valid only drops when a gap is taken, so back-to-back
  // items never see a low and a high valid in the same step
  task automatic send_cmd(in_item_t it);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic issue(logic [2:0] c, logic signed [WORD_W-1:0] v, logic [POS_W-1:0] p);
    in_item_t it;
    it.cmd      = c;
    it.value    = v;
    it.position = p;
    send_cmd(it);
  endtask

  // stop offering and wait until every pending result has come back
  task automatic wait_results_out();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
  endtask

  // capacity is only changed with the block idle
  task automatic write_capacity(logic [CAP_W-1:0] c);
    wait_results_out();
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= c;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // random command, biased toward push or pop; positions mostly land on
  // live entries, values half the time on the key pool so searches hit
  function automatic in_item_t next_random_command(int push_pct, int pop_pct);
    in_item_t    it;
    int          roll;
    int unsigned lvl;
    lvl  = sb.level;
    roll = $urandom_range(99);
    if (roll < push_pct) it.cmd = CMD_PUSH;
    else if (roll < push_pct + pop_pct) it.cmd = CMD_POP;
    else begin
      case ($urandom_range(10))
        0, 1:    it.cmd = CMD_PEEK;
        2, 3, 4: it.cmd = CMD_READ;
        5, 6, 7: it.cmd = CMD_WRITE;
        8, 9:    it.cmd = CMD_SEARCH;
        default: it.cmd = $urandom_range(1) ? CMD_SPARE_A : CMD_SPARE_B;
      endcase
    end
    if ($urandom_range(1)) it.value = key_pool[$urandom_range(5)];
    else it.value = $urandom;
    if (lvl != 0 && $urandom_range(3) != 0) it.position = POS_W'($urandom_range(lvl - 1));
    else it.position = POS_W'($urandom_range(DEPTH - 1));
    return it;
  endfunction

  task automatic run_phase(logic [CAP_W-1:0] c, int n, int push_pct, int pop_pct,
                           int idle_pct, int stall_pct);
    write_capacity(c);
    send_idle  = idle_pct;
    recv_stall = stall_pct;
    repeat (n) send_cmd(next_random_command(push_pct, pop_pct));
  endtask

  initial begin
    key_pool[0] = WORD_MIN;
    key_pool[1] = WORD_MAX;
    key_pool[2] = '0;
    key_pool[3] = -1;
    key_pool[4] = $urandom;
    key_pool[5] = $urandom;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // every command but push on an empty stack, spare codes included
    issue(CMD_POP, 32'sd5, 7'd0);
    issue(CMD_PEEK, 32'sd5, 7'd0);
    issue(CMD_READ, 32'sd5, 7'd0);
    issue(CMD_WRITE, 32'sd5, 7'd0);
    issue(CMD_SEARCH, 32'sd0, 7'd0);
    issue(CMD_SPARE_A, WORD_MAX, 7'd127);
    issue(CMD_SPARE_B, WORD_MIN, 7'd127);
    // extreme words
    issue(CMD_PUSH, WORD_MIN, 7'd0);
    issue(CMD_PUSH, WORD_MAX, 7'd127);
    issue(CMD_PUSH, -32'sd1, 7'd0);
    issue(CMD_PUSH, 32'sd0, 7'd0);
    issue(CMD_PEEK, 32'sd0, 7'd0);
    issue(CMD_READ, 32'sd0, 7'd0);
    issue(CMD_READ, 32'sd0, 7'd3);
    // positions at and past the fill level are invalid; one write lands on position 1
    issue(CMD_READ, 32'sd0, 7'd4);
    issue(CMD_READ, 32'sd0, 7'd127);
    issue(CMD_WRITE, WORD_MIN, 7'd1);
    issue(CMD_WRITE, 32'sd9, 7'd4);
    // two copies of the minimum now live, then a miss
    issue(CMD_SEARCH, WORD_MIN, 7'd0);
    issue(CMD_SEARCH, 32'sd12345, 7'd0);
    issue(CMD_POP, 32'sd0, 7'd0);

    // capacity below the fill level: push overflows until pops bring the level below it
    write_capacity(8'd2);
    issue(CMD_PUSH, 32'sd1, 7'd0);
    issue(CMD_POP, 32'sd0, 7'd0);
    issue(CMD_PUSH, 32'sd2, 7'd0);
    issue(CMD_POP, 32'sd0, 7'd0);
    issue(CMD_PUSH, 32'sd77, 7'd0);

    // random phases over several capacities and idling patterns
    run_phase(8'd128, 60, 45, 15, 0, 0);

    // long receiver hold-off with the sender pushing hard behind it
    write_capacity(8'd128);
    send_idle  = 0;
    recv_stall = 0;
    hold_req   = 1'b1;
    repeat (16) send_cmd(next_random_command(60, 20));
    // sender pauses until everything has drained
    wait_results_out();

    run_phase(8'd5, 70, 35, 30, 46, 0);
    run_phase(8'd1, 50, 35, 30, 0, 46);
    // capacity above the depth: fills right up to a full stack
    run_phase(8'd255, 140, 97, 0, 17, 17);
    // full stack: reads, writes and searches at random live positions
    run_phase(8'd128, 50, 10, 10, 0, 0);
    // zero capacity: every push overflows
    run_phase(8'd0, 40, 30, 40, 46, 0);
    run_phase(8'd64, 80, 40, 25, 0, 46);
    run_phase(8'd2, 60, 40, 30, 17, 17);

    wait_results_out();
    // a quiet stretch to catch any stray result
    repeat (DEPTH + 8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("FAILURE");
    $finish;
  end

endmodule

### files.f
+incdir+design
design/stksrch_pkg.sv
design/stksrch_cell.sv
design/stksrch_ctl.sv
design/array_stack_with_search.sv
dv/array_stack_with_search_test.sv
